FILE: src/sirt_pkg.sv
// Shared constants, types and helpers for the signed integer to radix text block.
package sirt_pkg;

  // Default width of the signed input integer
  localparam int VALUE_WIDTH_DEF = 32;

  // Alphabet limits
  localparam int MIN_RADIX  = 2;
  localparam int MAX_RADIX  = 16;
  localparam int ALPHA_SIZE = 16;

  // Field widths
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int ALPHA_W     = ALPHA_SIZE * CHAR_W;

  // Dividend bits retired per cycle by the digit divider
  localparam int DIV_BITS = 8;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Sign characters
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIX      = 2'd0,
    REG_ALPHA_LOW  = 2'd1,
    REG_ALPHA_HIGH = 2'd2
  } cfg_reg_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [ALPHA_W-1:0] alphabet;
    logic               ok;
  } cfg_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_SIGN,
    B_READ,
    B_EMIT
  } back_state_t;

  // Character for one digit value
  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alphabet,
                                                   input logic [DIGIT_W-1:0] idx);
    alpha_char = alphabet[idx*CHAR_W +: CHAR_W];
  endfunction

endpackage

FILE: src/sirt_value_if.sv
// Request channel carrying one signed integer.
interface sirt_value_if #(
  parameter int VALUE_WIDTH = sirt_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: src/sirt_char_if.sv
// Request channel carrying one text character with its end marker.
interface sirt_char_if;
  logic                        valid;
  logic                        ready;
  logic [sirt_pkg::CHAR_W-1:0] text_char;
  logic                        last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

FILE: src/sirt_cfg.sv
// Configuration registers and registered alphabet validity check.
module sirt_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sirt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sirt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sirt_pkg::cfg_t                   cfg
);
  import sirt_pkg::*;

  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] alpha_low;
  logic [CFG_DATA_W-1:0] alpha_high;
  logic [ALPHA_W-1:0]    alphabet;
  logic                  ok;
  logic                  ok_next;

  assign alphabet = {alpha_high, alpha_low};

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= '0;
      alpha_low  <= '0;
      alpha_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:      radix      <= cfg_data[RADIX_W-1:0];
        REG_ALPHA_LOW:  alpha_low  <= cfg_data;
        REG_ALPHA_HIGH: alpha_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Alphabet check: length in range, no sign characters, no repeats
  always_comb begin
    ok_next = (radix >= RADIX_W'(MIN_RADIX)) && (radix <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      if (RADIX_W'(i) < radix) begin
        if (alpha_char(alphabet, DIGIT_W'(i)) == PLUS_CHAR ||
            alpha_char(alphabet, DIGIT_W'(i)) == MINUS_CHAR) begin
          ok_next = 1'b0;
        end
        for (int j = i + 1; j < ALPHA_SIZE; j++) begin
          if (RADIX_W'(j) < radix &&
              alpha_char(alphabet, DIGIT_W'(i)) == alpha_char(alphabet, DIGIT_W'(j))) begin
            ok_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok <= 1'b0;
    end else begin
      ok <= ok_next;
    end
  end

  assign cfg.radix    = radix;
  assign cfg.alphabet = alphabet;
  assign cfg.ok       = ok;

endmodule

FILE: src/sirt_front.sv
// Front end: takes requests, drops them on a bad alphabet, forms sign and magnitude.
module sirt_front #(
  parameter int VALUE_WIDTH = sirt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  sirt_value_if.sink           number,
  input  sirt_pkg::cfg_t       cfg,
  input  logic                 q_full,
  output logic                 push,
  output logic [VALUE_WIDTH:0] push_data
);
  import sirt_pkg::*;

  logic [VALUE_WIDTH-1:0] held;
  logic                   held_valid;
  logic                   consume;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  // Held request leaves when dropped or queued
  assign consume      = held_valid && (!cfg.ok || !q_full);
  assign push         = held_valid && cfg.ok && !q_full;
  assign number.ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (number.ready) begin
      held_valid <= number.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (number.valid && number.ready) begin
      held <= number.value;
    end
  end

  // Unsigned magnitude, so the most negative value is exact
  assign neg       = held[VALUE_WIDTH-1];
  assign mag       = neg ? VALUE_WIDTH'(~held + 1'b1) : held;
  assign push_data = {neg, mag};

endmodule

FILE: src/sirt_queue.sv
// Short queue between front and back ends.
module sirt_queue #(
  parameter int WIDTH = sirt_pkg::VALUE_WIDTH_DEF + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);
  import sirt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != CNT_W'(QUEUE_DEPTH))
    else $error("queue written while full");

endmodule

FILE: src/sirt_back.sv
// Back end: digit divider, digit store and character emitter.
module sirt_back #(
  parameter int VALUE_WIDTH = sirt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sirt_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  logic [VALUE_WIDTH:0] q_head,
  output logic                 pop,
  sirt_char_if.source          text
);
  import sirt_pkg::*;

  localparam int PASSES = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int DW     = PASSES * DIV_BITS;
  localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int IDX_W  = $clog2(VALUE_WIDTH);
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

  back_state_t         state;
  back_state_t         state_next;
  logic [DW-1:0]       quo;
  logic [DW-1:0]       quo_step;
  logic [DIGIT_W-1:0]  rem;
  logic [DIGIT_W-1:0]  rem_step;
  logic [DIV_BITS-1:0] qbits;
  logic [PW-1:0]       pass;
  logic [CNT_W-1:0]    digit_count;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    rd_addr;
  logic                neg;
  logic                digit_done;
  logic                conv_done;

  logic [DIGIT_W-1:0]  digit_store [VALUE_WIDTH];
  logic [DIGIT_W-1:0]  rd_data;

  logic                out_valid;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;
  logic                out_free;
  logic                out_load;
  logic [CHAR_W-1:0]   out_char_next;
  logic                out_last_next;

  // Restoring division, DIV_BITS quotient bits per cycle; remainder stays below radix
  always_comb begin
    logic [RADIX_W-1:0] part;
    part  = {1'b0, rem};
    qbits = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      part = {part[DIGIT_W-1:0], quo[DW-1-k]};
      if (part >= cfg.radix) begin
        part                 = part - cfg.radix;
        qbits[DIV_BITS-1-k] = 1'b1;
      end
    end
    rem_step = part[DIGIT_W-1:0];
  end

  assign quo_step   = (quo << DIV_BITS) | DW'(qbits);
  assign digit_done = (state == B_DIV) && (pass == PW'(PASSES - 1));
  assign conv_done  = digit_done &&
                      ((quo_step == '0) || (digit_count == CNT_W'(VALUE_WIDTH - 1)));
  assign out_free   = !out_valid || text.ready;

  // Sequencer: next state and strobes
  always_comb begin
    state_next    = state;
    pop           = 1'b0;
    out_load      = 1'b0;
    out_char_next = alpha_char(cfg.alphabet, rd_data);
    out_last_next = (idx == '0);
    rd_addr       = idx;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (conv_done) begin
          state_next = neg ? B_SIGN : B_READ;
        end
      end
      B_SIGN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_char_next = MINUS_CHAR;
          out_last_next = 1'b0;
          state_next    = B_EMIT;
        end
      end
      B_READ: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx == '0) begin
            state_next = B_IDLE;
          end else begin
            rd_addr = idx - 1'b1;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      out_valid   <= 1'b0;
      digit_count <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        digit_count <= '0;
      end else if (digit_done) begin
        digit_count <= digit_count + 1'b1;
      end
    end
  end

  // Divider and emitter datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      neg  <= q_head[VALUE_WIDTH];
      quo  <= DW'(q_head[VALUE_WIDTH-1:0]);
      rem  <= '0;
      pass <= '0;
    end else if (state == B_DIV) begin
      quo <= quo_step;
      if (digit_done) begin
        rem  <= '0;
        pass <= '0;
        if (conv_done) begin
          idx <= digit_count[IDX_W-1:0];
        end
      end else begin
        rem  <= rem_step;
        pass <= pass + 1'b1;
      end
    end else if (state == B_EMIT && out_load) begin
      idx <= idx - 1'b1;
    end
    if (out_load) begin
      out_char <= out_char_next;
      out_last <= out_last_next;
    end
  end

  // Digit store, least significant digit at entry zero
  always_ff @(posedge clk) begin
    if (digit_done) begin
      digit_store[digit_count[IDX_W-1:0]] <= rem_step;
    end
    rd_data <= digit_store[rd_addr];
  end

  assign text.valid     = out_valid;
  assign text.text_char = out_char;
  assign text.last      = out_last;

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> ({1'b0, rem} < cfg.radix))
    else $error("partial remainder not below radix");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(VALUE_WIDTH))
    else $error("digit count beyond store depth");

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.last) |-> (text.text_char != MINUS_CHAR))
    else $error("sign character marked as final character");

endmodule

FILE: src/signed_int_to_radix_text.sv
// Writes a signed integer out as text in a configured radix, one character per request,
// most significant digit first, a leading '-' for negatives and last set on the final
// character. Program radix and the two alphabet words while idle; a request arriving
// with a bad alphabet (radix below 2 or above 16, a '+' or '-' in use, or a repeated
// character) gives no characters at all. A request passes the front end's holding
// register into the queue; the back end's divider retires eight dividend bits per
// cycle for each digit, and after a registered store read the characters leave at one
// per cycle while the receiver is ready. A two-entry queue lets the front end take
// further requests while the back end works.
module signed_int_to_radix_text #(
  parameter int VALUE_WIDTH = sirt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  sirt_value_if.sink                      number,
  sirt_char_if.source                     text,
  input  logic                            cfg_we,
  input  logic [sirt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sirt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sirt_pkg::*;

  cfg_t                 cfg;
  logic                 push;
  logic [VALUE_WIDTH:0] push_data;
  logic                 pop;
  logic [VALUE_WIDTH:0] q_head;
  logic                 q_full;
  logic                 q_empty;

  // Configuration and alphabet check
  sirt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Request intake
  sirt_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .number    (number),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue
  sirt_queue #(.WIDTH(VALUE_WIDTH + 1)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Conversion and character output
  sirt_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .text    (text)
  );

endmodule

FILE: bench/tb_signed_int_to_radix_text.sv
// Testbench for signed_int_to_radix_text: directed table, then randomised alphabets and values.
module tb_signed_int_to_radix_text;
  import sirt_pkg::*;

  localparam int VW            = 32;
  localparam int SETTLE_CYCLES = 250;     // longest back end pass, radix 2, with margin
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {FLAW_NONE, FLAW_SHORT, FLAW_WIDE, FLAW_SIGN, FLAW_REPEAT} alpha_flaw_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_exp_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [VW-1:0]          value;
    bit                     typed;
    string                  text;
  } script_row_t;

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sirt_value_if #(.VALUE_WIDTH(VW)) number_ch ();
  sirt_char_if                      text_ch ();

  signed_int_to_radix_text #(.VALUE_WIDTH(VW)) dut (
    .clk       (clk),
    .rst       (rst),
    .number    (number_ch),
    .text      (text_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the configuration registers
  logic [RADIX_W-1:0]    mirror_radix;
  logic [CFG_DATA_W-1:0] mirror_alpha_low;
  logic [CFG_DATA_W-1:0] mirror_alpha_high;

  char_exp_t   pending_chars[$];
  script_row_t script[$];
  int          mismatch_count;
  int          cycle_count;
  bit          steady;        // no idling on either side
  bit          hold_request;  // ask the receiver for one long hold-off
  bit          need_settle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("signed_int_to_radix_text verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 50) $display("MISMATCH: %s", what);
    mismatch_count++;
  endtask

  function automatic logic [CHAR_W-1:0] glyph_at(input logic [DIGIT_W-1:0] d);
    logic [ALPHA_W-1:0] alpha;
    alpha = {mirror_alpha_high, mirror_alpha_low};
    return alpha[d*CHAR_W +: CHAR_W];
  endfunction

  // Predict the characters of one number under the mirrored configuration
  function automatic void format_expected(input logic [VW-1:0] v);
    logic [DIGIT_W-1:0] digits [VW];
    logic [VW-1:0]      mag;
    logic [VW-1:0]      base;
    int                 r;
    int                 n;
    r = int'(mirror_radix);
    if (r < MIN_RADIX || r > MAX_RADIX) return;
    for (int i = 0; i < r; i++) begin
      if (glyph_at(DIGIT_W'(i)) == PLUS_CHAR || glyph_at(DIGIT_W'(i)) == MINUS_CHAR) return;
      for (int j = i + 1; j < r; j++)
        if (glyph_at(DIGIT_W'(j)) == glyph_at(DIGIT_W'(i))) return;
    end
    // magnitude is unsigned, so the most negative value survives
    base = VW'(mirror_radix);
    mag  = v[VW-1] ? (~v + 1'b1) : v;
    n    = 0;
    do begin
      digits[n] = DIGIT_W'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0 && n < VW);
    if (v[VW-1]) pending_chars.push_back('{ch: MINUS_CHAR, last: 1'b0});
    for (int i = n - 1; i >= 0; i--)
      pending_chars.push_back('{ch: glyph_at(digits[i]), last: (i == 0)});
  endfunction

  // One register write, strobe high for a single cycle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIX:      mirror_radix      = data[RADIX_W-1:0];
      REG_ALPHA_LOW:  mirror_alpha_low  = data;
      REG_ALPHA_HIGH: mirror_alpha_high = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one request; returns at the edge that accepts it, valid left high
  task automatic offer_value(input logic [VW-1:0] v, input bit typed, input string text);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      number_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    number_ch.valid <= 1'b1;
    number_ch.value <= v;
    do @(negedge clk); while (!number_ch.ready);
    @(posedge clk);
    if (typed) begin
      for (int i = 0; i < text.len(); i++)
        pending_chars.push_back('{ch: text[i], last: (i == text.len() - 1)});
    end else begin
      format_expected(v);
    end
  endtask

  task automatic await_results();
    number_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Idle before a register write: results drained, then the block's own latency
  task automatic wait_idle();
    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_row(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    script.push_back('{is_cfg: 1'b1, idx: idx, data: data, value: '0, typed: 1'b0, text: ""});
  endtask

  task automatic item_row(input logic [VW-1:0] v, input bit typed, input string text);
    script.push_back('{is_cfg: 1'b0, idx: '0, data: '0, value: v, typed: typed, text: text});
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    text_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        text_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = steady ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          text_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      text_ch.ready <= 1'b1;
      do @(negedge clk); while (!text_ch.valid);
      @(posedge clk);
    end
  end

  // Result checker, sampled mid-cycle so both sides are settled
  char_exp_t want;
  always @(negedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char %h last %b", text_ch.text_char, text_ch.last));
      end else begin
        want = pending_chars.pop_front();
        if (text_ch.text_char !== want.ch)
          flag_mismatch($sformatf("text_char %h, wanted %h", text_ch.text_char, want.ch));
        if (text_ch.last !== want.last)
          flag_mismatch($sformatf("last %b, wanted %b (char %h)", text_ch.last, want.last,
                                  want.ch));
      end
    end
  end

  // Stimulus
  initial begin
    script_row_t       row;
    alpha_flaw_t       flaw;
    logic [CHAR_W-1:0] glyphs [ALPHA_SIZE];
    bit                used [256];
    logic [CHAR_W-1:0] c;
    logic [CFG_DATA_W-1:0] lo_word, hi_word, radix_word;
    logic [VW-1:0]     v;
    int                r, count, first, a, b;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    number_ch.valid   = 1'b0;
    number_ch.value   = '0;
    mirror_radix      = '0;
    mirror_alpha_low  = '0;
    mirror_alpha_high = '0;
    mismatch_count    = 0;
    cycle_count       = 0;
    steady            = 1'b0;
    hold_request      = 1'b0;
    need_settle       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // after reset the radix is zero: nothing comes out
    item_row(32'd5, 1, "");
    item_row(32'h8000_0000, 1, "");
    // decimal, unused digits full of '+'
    cfg_row(REG_RADIX, 64'd10);
    cfg_row(REG_ALPHA_LOW, 64'h3736_3534_3332_3130);
    cfg_row(REG_ALPHA_HIGH, 64'h2B2B_2B2B_2B2B_3938);
    item_row(32'd0, 1, "0");
    item_row(32'd1, 1, "1");
    item_row(32'hFFFF_FFFF, 1, "-1");
    item_row(32'h7FFF_FFFF, 1, "2147483647");
    item_row(32'h8000_0000, 1, "-2147483648");
    item_row(32'd12345, 0, "");
    // hexadecimal, largest radix
    cfg_row(REG_ALPHA_HIGH, 64'h4645_4443_4241_3938);
    cfg_row(REG_RADIX, 64'd16);
    item_row(32'h7FFF_FFFF, 1, "7FFFFFFF");
    item_row(32'h8000_0000, 1, "-80000000");
    item_row(32'd255, 1, "FF");
    // binary: the most negative value gives the longest text
    cfg_row(REG_RADIX, 64'd2);
    item_row(32'h8000_0000, 0, "");
    item_row(32'h7FFF_FFFF, 0, "");
    // radix above the limit, then below two
    cfg_row(REG_RADIX, 64'd17);
    item_row(32'd7, 1, "");
    cfg_row(REG_RADIX, 64'd1);
    item_row(32'd7, 1, "");
    // only the low five bits of the radix write count
    cfg_row(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFE3);
    item_row(32'd5, 1, "12");
    // a write to an unknown index changes nothing
    cfg_row(REG_UNUSED, 64'd16);
    item_row(32'd8, 1, "22");
    // sign characters inside the alphabet in use
    cfg_row(REG_RADIX, 64'd10);
    cfg_row(REG_ALPHA_LOW, 64'h3736_3534_2D32_3130);
    item_row(32'd1, 1, "");
    cfg_row(REG_ALPHA_LOW, 64'h3736_3534_3332_312B);
    item_row(32'd1, 1, "");
    // repeated character in the high word
    cfg_row(REG_ALPHA_LOW, 64'h3736_3534_3332_3130);
    cfg_row(REG_ALPHA_HIGH, 64'h2B2B_2B2B_2B2B_3038);
    item_row(32'd42, 1, "");
    // a zero byte is an ordinary digit
    cfg_row(REG_RADIX, 64'd2);
    cfg_row(REG_ALPHA_LOW, 64'h0000_0000_0000_4100);
    item_row(32'd2, 0, "");
    item_row(32'hFFFF_FFFD, 0, "");

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        if (need_settle) begin
          wait_idle();
          need_settle = 1'b0;
        end
        write_reg(row.idx, row.data);
      end else begin
        offer_value(row.value, row.typed, row.text);
        need_settle = 1'b1;
      end
    end

    // Random phases, each with a fresh alphabet
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       begin r = 2;  flaw = FLAW_NONE;   end
        1:       begin r = 16; flaw = FLAW_NONE;   end
        4:       begin r = $urandom_range(0, 1);   flaw = FLAW_SHORT;  end
        5:       begin r = $urandom_range(2, 16);  flaw = FLAW_SIGN;   end
        7:       begin r = $urandom_range(17, 31); flaw = FLAW_WIDE;   end
        8:       begin r = $urandom_range(2, 16);  flaw = FLAW_REPEAT; end
        default: begin r = $urandom_range(2, 16);  flaw = FLAW_NONE;   end
      endcase
      foreach (used[u]) used[u] = 1'b0;
      for (int i = 0; i < ALPHA_SIZE; i++) begin
        if (i < r) begin
          do c = CHAR_W'($urandom_range(0, 255));
          while (c == PLUS_CHAR || c == MINUS_CHAR || used[c]);
          used[c] = 1'b1;
        end else begin
          c = CHAR_W'($urandom);
        end
        glyphs[i] = c;
      end
      if (flaw == FLAW_SIGN)
        glyphs[$urandom_range(0, r - 1)] = $urandom_range(0, 1) ? PLUS_CHAR : MINUS_CHAR;
      if (flaw == FLAW_REPEAT) begin
        a = $urandom_range(0, r - 2);
        b = $urandom_range(a + 1, r - 1);
        glyphs[b] = glyphs[a];
      end
      for (int i = 0; i < 8; i++) begin
        lo_word[i*CHAR_W +: CHAR_W] = glyphs[i];
        hi_word[i*CHAR_W +: CHAR_W] = glyphs[i+8];
      end
      radix_word = {$urandom, $urandom};
      radix_word[RADIX_W-1:0] = RADIX_W'(r);
      // registers written in a rotating order
      first = $urandom_range(0, 2);
      for (int w = 0; w < 3; w++) begin
        case ((first + w) % 3)
          0: write_reg(REG_RADIX, radix_word);
          1: write_reg(REG_ALPHA_LOW, lo_word);
          default: write_reg(REG_ALPHA_HIGH, hi_word);
        endcase
      end

      steady       = (p == 2) || ($urandom_range(0, 4) == 0);
      hold_request = (p == 3);
      count        = (flaw == FLAW_NONE) ? 18 : 4;
      for (int n = 0; n < count; n++) begin
        // mid-phase pause until every character is out
        if (p == 6 && n == 9) await_results();
        case ($urandom_range(0, 4))
          0, 1: v = $urandom;
          2: begin
            v = $urandom_range(0, 50);
            if ($urandom_range(0, 1)) v = -v;
          end
          3: begin
            v = 32'd1 << $urandom_range(0, VW - 1);
            if ($urandom_range(0, 1)) v = v - 1'b1;
            if ($urandom_range(0, 1)) v = -v;
          end
          default: begin
            case ($urandom_range(0, 3))
              0: v = 32'd0;
              1: v = 32'hFFFF_FFFF;
              2: v = 32'h7FFF_FFFF;
              default: v = 32'h8000_0000;
            endcase
          end
        endcase
        offer_value(v, 0, "");
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("signed_int_to_radix_text verification clean");
    end else begin
      $display("signed_int_to_radix_text verification failed");
    end
    $finish;
  end

endmodule
